/* design/aesi_pkg.sv */
// aesi_pkg: shared types, codes and constants for the escape sequence interpreter.
// No dependencies.
package aesi_pkg;

    localparam int MAX_ARGS = 8;
    localparam int AIW = $clog2(MAX_ARGS);
    localparam int ACW = $clog2(MAX_ARGS + 1);
    localparam logic [15:0] ARG_MAX_VAL = 16'd32767;

    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LBR = 8'h5b;
    localparam logic [7:0] CH_RBR = 8'h5d;
    localparam logic [7:0] CH_QM = 8'h3f;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;

    localparam logic [2:0] REG_ROWS = 3'd0;
    localparam logic [2:0] REG_COLS = 3'd1;
    localparam logic [2:0] REG_FG = 3'd2;
    localparam logic [2:0] REG_BG = 3'd3;
    localparam logic [2:0] REG_FLAGS = 3'd4;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_MOVE = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_SCROLL = 3'd3;
    localparam logic [2:0] CMD_ATTR = 3'd4;
    localparam logic [2:0] CMD_CURSOR = 3'd5;

    typedef enum logic [2:0] {
        PS_IDLE, PS_ESC, PS_BRACKET, PS_NUMERIC, PS_STRING, PS_IGNORE
    } parse_state_t;

    typedef enum logic [1:0] {KIND_CSI, KIND_OSC, KIND_PRIV} seq_kind_t;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_PARSE, SQ_SGR, SQ_MUL, SQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic [7:0] cursor_row;
        logic [7:0] cursor_col;
    } in_req_t;

    typedef struct packed {
        logic        pass_through;
        logic [2:0]  command;
        logic [7:0]  target_row;
        logic [7:0]  target_col;
        logic [15:0] clear_count;
        logic signed [15:0] scroll_rows;
        logic [2:0]  attr_fg;
        logic [2:0]  attr_bg;
        logic [8:0]  attr_flags;
        logic        cursor_visible;
    } out_req_t;

    typedef struct packed {
        logic [2:0] fg;
        logic [2:0] bg;
        logic [8:0] flags;
    } attr_t;

    // one SGR code applied to an attribute set
    function automatic attr_t sgr_apply(attr_t a, logic [15:0] code, attr_t dflt);
        attr_t r;
        r = a;
        case (code)
            16'd0: r = dflt;
            16'd39: r.fg = dflt.fg;
            16'd49: r.bg = dflt.bg;
            16'd1: r.flags[1:0] = 2'd2;
            16'd2: r.flags[1:0] = 2'd0;
            16'd21, 16'd22: r.flags[1:0] = 2'd1;
            16'd3: r.flags[2] = 1'b1;
            16'd23: r.flags[2] = 1'b0;
            16'd4: r.flags[3] = 1'b1;
            16'd24: r.flags[3] = 1'b0;
            16'd5: r.flags[5:4] = 2'd1;
            16'd6: r.flags[5:4] = 2'd2;
            16'd25: r.flags[5:4] = 2'd0;
            16'd7: r.flags[6] = 1'b1;
            16'd27: r.flags[6] = 1'b0;
            16'd8: r.flags[7] = 1'b1;
            16'd28: r.flags[7] = 1'b0;
            16'd9: r.flags[8] = 1'b1;
            16'd29: r.flags[8] = 1'b0;
            default:
            begin
                if (code >= 16'd30 && code <= 16'd37)
                    r.fg = 3'(code - 16'd30);
                else if (code >= 16'd40 && code <= 16'd47)
                    r.bg = 3'(code - 16'd40);
            end
        endcase
        return r;
    endfunction

endpackage

/* design/aesi_mul.sv */
// aesi_mul: shared shift-add multiplier, 8 x 8 bits, one bit per cycle.
// Depends on nothing but the clock and reset.
module aesi_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  a,
    input  logic [7:0]  b,
    output logic        busy,
    output logic [15:0] product
);
    logic [15:0] acc_reg, acc_next;
    logic [15:0] mcand_reg, mcand_next;
    logic [7:0]  mplier_reg, mplier_next;
    logic [3:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            acc_next = '0;
            mcand_next = {8'd0, a};
            mplier_next = b;
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next = {mcand_reg[14:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[7:1]};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    assign busy = cnt_reg != 4'd0;
    assign product = acc_reg;
endmodule

/* design/ansi_escape_sequence_interpreter.sv */
// ansi_escape_sequence_interpreter: top level, parser, SGR walk and result register.
// Depends on aesi_pkg and aesi_mul.
//
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_req  (aesi_pkg::in_req_t)
// out     | out_valid | out_stall | out_req (aesi_pkg::out_req_t)
// cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// A byte passes SQ_PARSE and SQ_DONE; an SGR final applies its stored arguments in
// turn in SQ_SGR, an erase J waits in SQ_MUL for the shared 8x8 multiplier.
// One request at a time; in_stall is high from acceptance until the result is loaded.
// A finished result waits in the output register while out_stall is high; the next
// request is then held in its last step until the output register frees.
// Reset is asynchronous; the argument store has no reset.
module ansi_escape_sequence_interpreter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  aesi_pkg::in_req_t  in_req,
    output logic               out_valid,
    input  logic               out_stall,
    output aesi_pkg::out_req_t out_req,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    aesi_pkg::seq_state_t   sq_reg, sq_next;
    aesi_pkg::parse_state_t ps_reg, ps_next;
    aesi_pkg::seq_kind_t    kind_reg, kind_next;
    logic [aesi_pkg::ACW-1:0] cnt_reg, cnt_next;
    logic [aesi_pkg::ACW-1:0] idx_reg, idx_next;
    logic [7:0]  sav_row_reg, sav_row_next, sav_col_reg, sav_col_next;
    aesi_pkg::attr_t attr_reg, attr_next;
    logic        sesc_reg, sesc_next;
    logic [7:0]  rows_reg, cols_reg;
    aesi_pkg::attr_t dflt_reg;
    aesi_pkg::in_req_t  inr_reg;
    aesi_pkg::out_req_t res_reg, res_next;
    aesi_pkg::out_req_t obuf_reg, obuf_next;
    logic        ov_reg, ov_next;
    logic [1:0]  jmode_reg, jmode_next;

    logic [15:0] args [aesi_pkg::MAX_ARGS];
    logic        arg_we;
    logic [aesi_pkg::AIW-1:0] arg_wa;
    logic [15:0] arg_wd;
    logic [15:0] arg0, arg1, argi, arglast;

    logic        mul_start, mul_busy;
    logic [7:0]  mul_a, mul_b;
    logic [15:0] mul_p;

    aesi_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .busy(mul_busy), .product(mul_p)
    );

    always_ff @(posedge clk)
    begin
        if (arg_we)
            args[arg_wa] <= arg_wd;
    end

    localparam int LASTW = aesi_pkg::ACW;
    logic [LASTW-1:0] last_i;
    assign last_i = cnt_reg - LASTW'(1);
    assign arg0 = args[0];
    assign arg1 = args[1 % aesi_pkg::MAX_ARGS];
    assign argi = args[idx_reg[aesi_pkg::AIW-1:0]];
    assign arglast = args[last_i[aesi_pkg::AIW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= aesi_pkg::SQ_IDLE;
            ps_reg <= aesi_pkg::PS_IDLE;
            kind_reg <= aesi_pkg::KIND_CSI;
            cnt_reg <= '0;
            idx_reg <= '0;
            sav_row_reg <= '0;
            sav_col_reg <= '0;
            attr_reg <= '{fg: 3'd7, bg: 3'd0, flags: 9'd1};
            sesc_reg <= 1'b0;
            rows_reg <= 8'd25;
            cols_reg <= 8'd80;
            dflt_reg <= '{fg: 3'd7, bg: 3'd0, flags: 9'd1};
            ov_reg <= 1'b0;
            jmode_reg <= '0;
        end
        else
        begin
            sq_reg <= sq_next;
            ps_reg <= ps_next;
            kind_reg <= kind_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            sav_row_reg <= sav_row_next;
            sav_col_reg <= sav_col_next;
            attr_reg <= attr_next;
            sesc_reg <= sesc_next;
            ov_reg <= ov_next;
            jmode_reg <= jmode_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    aesi_pkg::REG_ROWS: rows_reg <= cfg_data[7:0];
                    aesi_pkg::REG_COLS: cols_reg <= cfg_data[7:0];
                    aesi_pkg::REG_FG: dflt_reg.fg <= cfg_data[2:0];
                    aesi_pkg::REG_BG: dflt_reg.bg <= cfg_data[2:0];
                    aesi_pkg::REG_FLAGS: dflt_reg.flags <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        obuf_reg <= obuf_next;
        if (in_valid && !in_stall)
            inr_reg <= in_req;
    end

    // clip helpers on 18-bit signed values
    function automatic logic [7:0] clip_rel(logic signed [17:0] v, logic [7:0] size);
        logic signed [17:0] lim;
        lim = (size == 8'd0) ? 18'sd0 : $signed({10'd0, size}) - 18'sd1;
        if (v < 0)
            return 8'd0;
        else if (v > lim)
            return lim[7:0];
        return v[7:0];
    endfunction

    // a negative absolute target keeps the current coordinate as it is
    function automatic logic [7:0] clip_abs(logic signed [17:0] v, logic [7:0] cur,
                                            logic [7:0] size);
        if (v < 0)
            return cur;
        return clip_rel(v, size);
    endfunction

    logic [7:0] ch, cr, cc;
    logic digit, one;
    logic signed [17:0] a1s, h0s, h1s, crs, ccs, colss;
    logic [19:0] acc10;
    logic signed [17:0] cnt_s;

    always_comb
    begin
        ch = inr_reg.in_byte;
        cr = inr_reg.cursor_row;
        cc = inr_reg.cursor_col;
        digit = ch >= 8'h30 && ch <= 8'h39;
        one = cnt_reg <= aesi_pkg::ACW'(1);
        a1s = (cnt_reg != '0) ? $signed({2'd0, arg0}) : 18'sd1;
        h0s = (cnt_reg >= aesi_pkg::ACW'(1)) ? $signed({2'd0, arg0}) : 18'sd1;
        h1s = (cnt_reg >= aesi_pkg::ACW'(2)) ? $signed({2'd0, arg1}) : 18'sd1;
        crs = $signed({10'd0, cr});
        ccs = $signed({10'd0, cc});
        colss = $signed({10'd0, cols_reg});
        acc10 = {4'd0, arglast} * 20'd10 + 20'(ch - 8'h30);
        cnt_s = '0;

        sq_next = sq_reg;
        ps_next = ps_reg;
        kind_next = kind_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        sav_row_next = sav_row_reg;
        sav_col_next = sav_col_reg;
        attr_next = attr_reg;
        sesc_next = sesc_reg;
        res_next = res_reg;
        obuf_next = obuf_reg;
        ov_next = ov_reg;
        jmode_next = jmode_reg;
        arg_we = 1'b0;
        arg_wa = cnt_reg[aesi_pkg::AIW-1:0];
        arg_wd = '0;
        mul_start = 1'b0;
        mul_a = cols_reg;
        mul_b = rows_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (sq_reg)
            aesi_pkg::SQ_IDLE:
            begin
                if (in_valid)
                    sq_next = aesi_pkg::SQ_PARSE;
            end
            aesi_pkg::SQ_PARSE:
            begin
                res_next = '0;
                sq_next = aesi_pkg::SQ_DONE;
                case (ps_reg)
                    aesi_pkg::PS_IDLE:
                    begin
                        if (ch == aesi_pkg::CH_ESC)
                            ps_next = aesi_pkg::PS_ESC;
                        else
                            res_next.pass_through = 1'b1;
                    end
                    aesi_pkg::PS_ESC:
                    begin
                        if (ch == aesi_pkg::CH_LBR || ch == aesi_pkg::CH_RBR)
                        begin
                            kind_next = (ch == aesi_pkg::CH_LBR) ? aesi_pkg::KIND_CSI
                                                                 : aesi_pkg::KIND_OSC;
                            cnt_next = '0;
                            ps_next = aesi_pkg::PS_BRACKET;
                        end
                        else if (ch == aesi_pkg::CH_LPAR || ch == aesi_pkg::CH_RPAR)
                            ps_next = aesi_pkg::PS_IGNORE;
                        else if (ch != aesi_pkg::CH_ESC)
                        begin
                            ps_next = aesi_pkg::PS_IDLE;
                            res_next.pass_through = 1'b1;
                        end
                    end
                    aesi_pkg::PS_BRACKET, aesi_pkg::PS_NUMERIC:
                    begin
                        if (digit && ps_reg == aesi_pkg::PS_BRACKET)
                        begin
                            if (cnt_reg < aesi_pkg::ACW'(aesi_pkg::MAX_ARGS))
                            begin
                                arg_we = 1'b1;
                                arg_wd = 16'(ch - 8'h30);
                                cnt_next = cnt_reg + aesi_pkg::ACW'(1);
                            end
                            ps_next = aesi_pkg::PS_NUMERIC;
                        end
                        else if (digit)
                        begin
                            if (cnt_reg != '0)
                            begin
                                arg_we = 1'b1;
                                arg_wa = last_i[aesi_pkg::AIW-1:0];
                                arg_wd = (acc10 > 20'(aesi_pkg::ARG_MAX_VAL))
                                         ? aesi_pkg::ARG_MAX_VAL : acc10[15:0];
                            end
                        end
                        else if (ch == aesi_pkg::CH_SEMI)
                        begin
                            if (cnt_reg < aesi_pkg::ACW'(aesi_pkg::MAX_ARGS))
                            begin
                                arg_we = 1'b1;
                                cnt_next = cnt_reg + aesi_pkg::ACW'(1);
                            end
                            if (ps_reg == aesi_pkg::PS_NUMERIC
                                && kind_reg == aesi_pkg::KIND_OSC)
                            begin
                                ps_next = aesi_pkg::PS_STRING;
                                sesc_next = 1'b0;
                            end
                        end
                        else if (ch == aesi_pkg::CH_QM && ps_reg == aesi_pkg::PS_BRACKET)
                            kind_next = aesi_pkg::KIND_PRIV;
                        else
                        begin
                            ps_next = aesi_pkg::PS_IDLE;
                            if (kind_reg == aesi_pkg::KIND_PRIV)
                            begin
                                if ((ch == "h" || ch == "l") && cnt_reg == aesi_pkg::ACW'(1)
                                    && arg0 == 16'd25)
                                begin
                                    res_next.command = aesi_pkg::CMD_CURSOR;
                                    res_next.cursor_visible = ch == "h";
                                end
                            end
                            else if (kind_reg == aesi_pkg::KIND_CSI)
                            begin
                                case (ch)
                                    "A", "B", "E", "F":
                                    if (one)
                                    begin
                                        res_next.command = aesi_pkg::CMD_MOVE;
                                        res_next.target_row = clip_rel(
                                            (ch == "A" || ch == "F") ? crs - a1s : crs + a1s,
                                            rows_reg);
                                        res_next.target_col = (ch == "E" || ch == "F")
                                            ? clip_abs(18'sd0, cc, cols_reg)
                                            : clip_rel(ccs, cols_reg);
                                    end
                                    "C", "D":
                                    if (one)
                                    begin
                                        res_next.command = aesi_pkg::CMD_MOVE;
                                        res_next.target_row = clip_rel(crs, rows_reg);
                                        res_next.target_col = clip_rel(
                                            (ch == "D") ? ccs - a1s : ccs + a1s, cols_reg);
                                    end
                                    "G":
                                    if (one)
                                    begin
                                        res_next.command = aesi_pkg::CMD_MOVE;
                                        res_next.target_row = clip_rel(crs, rows_reg);
                                        res_next.target_col = clip_abs(a1s - 18'sd1, cc,
                                                                       cols_reg);
                                    end
                                    "d":
                                    if (one)
                                    begin
                                        res_next.command = aesi_pkg::CMD_MOVE;
                                        res_next.target_row = clip_abs(a1s - 18'sd1, cr,
                                                                       rows_reg);
                                        res_next.target_col = clip_rel(ccs, cols_reg);
                                    end
                                    "H", "f":
                                    if (cnt_reg <= aesi_pkg::ACW'(2))
                                    begin
                                        res_next.command = aesi_pkg::CMD_MOVE;
                                        res_next.target_row = clip_abs(h0s - 18'sd1, cr,
                                                                       rows_reg);
                                        res_next.target_col = clip_abs(h1s - 18'sd1, cc,
                                                                       cols_reg);
                                    end
                                    "u":
                                    if (cnt_reg == '0)
                                    begin
                                        res_next.command = aesi_pkg::CMD_MOVE;
                                        res_next.target_row = clip_abs(
                                            $signed({10'd0, sav_row_reg}), cr, rows_reg);
                                        res_next.target_col = clip_abs(
                                            $signed({10'd0, sav_col_reg}), cc, cols_reg);
                                    end
                                    "s":
                                    if (cnt_reg == '0)
                                    begin
                                        sav_row_next = cr;
                                        sav_col_next = cc;
                                    end
                                    "S", "T":
                                    if (one)
                                    begin
                                        res_next.command = aesi_pkg::CMD_SCROLL;
                                        res_next.scroll_rows = (ch == "S")
                                            ? 16'(-a1s) : 16'(a1s);
                                    end
                                    "K":
                                    if (one && (cnt_reg == '0 || arg0 <= 16'd2))
                                    begin
                                        res_next.command = aesi_pkg::CMD_CLEAR;
                                        res_next.target_row = cr;
                                        if (cnt_reg == '0 || arg0 == 16'd0)
                                        begin
                                            res_next.target_col = cc;
                                            cnt_s = colss - ccs;
                                            res_next.clear_count = (cnt_s < 0) ? 16'd0
                                                                   : cnt_s[15:0];
                                        end
                                        else if (arg0 == 16'd1)
                                            res_next.clear_count = {8'd0, cc};
                                        else
                                            res_next.clear_count = {8'd0, cols_reg};
                                    end
                                    "J":
                                    if (one && (cnt_reg == '0 || arg0 <= 16'd2))
                                    begin
                                        res_next.command = aesi_pkg::CMD_CLEAR;
                                        jmode_next = (cnt_reg == '0) ? 2'd0 : arg0[1:0];
                                        mul_start = 1'b1;
                                        mul_a = cols_reg;
                                        if (cnt_reg == '0 || arg0 == 16'd0)
                                        begin
                                            res_next.target_row = cr;
                                            res_next.target_col = cc;
                                            mul_b = 8'(rows_reg - cr - 8'd1);
                                        end
                                        else if (arg0 == 16'd1)
                                            mul_b = cr;
                                        else
                                            mul_b = rows_reg;
                                        sq_next = aesi_pkg::SQ_MUL;
                                    end
                                    "m":
                                    begin
                                        res_next.command = aesi_pkg::CMD_ATTR;
                                        idx_next = '0;
                                        if (cnt_reg == '0)
                                            attr_next = dflt_reg;
                                        else
                                            sq_next = aesi_pkg::SQ_SGR;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                    aesi_pkg::PS_STRING:
                    begin
                        if (ch == aesi_pkg::CH_BS || (ch == aesi_pkg::CH_BSL && sesc_reg))
                        begin
                            ps_next = aesi_pkg::PS_IDLE;
                            sesc_next = 1'b0;
                        end
                        else
                            sesc_next = ch == aesi_pkg::CH_ESC;
                    end
                    default: ps_next = aesi_pkg::PS_IDLE;
                endcase
            end
            aesi_pkg::SQ_SGR:
            begin
                attr_next = aesi_pkg::sgr_apply(attr_reg, argi, dflt_reg);
                idx_next = idx_reg + aesi_pkg::ACW'(1);
                if (idx_next == cnt_reg)
                    sq_next = aesi_pkg::SQ_DONE;
            end
            aesi_pkg::SQ_MUL:
            begin
                // the product is valid once the multiplier stops
                if (!mul_busy)
                begin
                    sq_next = aesi_pkg::SQ_DONE;
                    if (jmode_reg == 2'd0)
                    begin
                        // cursor below the last row: the count is never positive
                        if (cr >= rows_reg)
                            res_next.clear_count = 16'd0;
                        else
                        begin
                            cnt_s = (colss - ccs) + $signed({2'd0, mul_p});
                            res_next.clear_count = (cnt_s < 0) ? 16'd0 : cnt_s[15:0];
                        end
                    end
                    else if (jmode_reg == 2'd1)
                        res_next.clear_count = mul_p + {8'd0, cc};
                    else
                        res_next.clear_count = mul_p;
                end
            end
            aesi_pkg::SQ_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    obuf_next = res_reg;
                    obuf_next.attr_fg = attr_reg.fg;
                    obuf_next.attr_bg = attr_reg.bg;
                    obuf_next.attr_flags = attr_reg.flags;
                    ov_next = 1'b1;
                    sq_next = aesi_pkg::SQ_IDLE;
                end
            end
            default: sq_next = aesi_pkg::SQ_IDLE;
        endcase
    end

    assign in_stall = sq_reg != aesi_pkg::SQ_IDLE;
    assign out_valid = ov_reg;
    assign out_req = obuf_reg;

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sq_reg == aesi_pkg::SQ_PARSE |-> in_stall) else $error("busy without stall");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !($rose(ov_reg))) else $error("early result");
    a_sgr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_reg == aesi_pkg::SQ_SGR |-> idx_reg < cnt_reg) else $error("sgr index");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= aesi_pkg::ACW'(aesi_pkg::MAX_ARGS)) else $error("arg count");
endmodule

/* test/aesi_checker.sv */
// aesi_checker: watches the byte and result channels of the escape sequence interpreter,
// predicts each result and compares it. Depends on aesi_pkg.
module aesi_checker
    import aesi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  in_req_t  in_req,
    input  logic     out_valid,
    input  logic     out_stall,
    input  out_req_t out_req,
    input  logic     cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    output int       errors,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] rows_q = 8'd25;
    logic [7:0] cols_q = 8'd80;
    logic [2:0] dfg = 3'd7;
    logic [2:0] dbg = 3'd0;
    logic [8:0] dflags = 9'd1;

    parse_state_t pstate = PS_IDLE;
    seq_kind_t kind = KIND_CSI;
    logic [15:0] args [MAX_ARGS];
    int nargs = 0;
    logic [7:0] sv_row = 0, sv_col = 0;
    logic [2:0] cur_fg = 3'd7, cur_bg = 3'd0;
    logic [8:0] cur_flags = 9'd1;
    logic str_esc = 0;

    out_req_t results_due[$];

    assign pending = results_due.size();

    function automatic logic [7:0] clip(int v, bit absolute, int cur, logic [7:0] size);
        int lim;
        lim = size != 0 ? int'(size) - 1 : 0;
        if (!absolute)
            v += cur;
        if (v < 0)
            v = absolute ? cur : 0;
        else if (v > lim)
            v = lim;
        return 8'(v);
    endfunction

    function automatic void sgr(int code);
        case (code)
            0:
            begin
                cur_fg = dfg;
                cur_bg = dbg;
                cur_flags = dflags;
            end
            39: cur_fg = dfg;
            49: cur_bg = dbg;
            1: cur_flags[1:0] = 2'd2;
            2: cur_flags[1:0] = 2'd0;
            21, 22: cur_flags[1:0] = 2'd1;
            3: cur_flags[2] = 1;
            23: cur_flags[2] = 0;
            4: cur_flags[3] = 1;
            24: cur_flags[3] = 0;
            5: cur_flags[5:4] = 2'd1;
            6: cur_flags[5:4] = 2'd2;
            25: cur_flags[5:4] = 2'd0;
            7: cur_flags[6] = 1;
            27: cur_flags[6] = 0;
            8: cur_flags[7] = 1;
            28: cur_flags[7] = 0;
            9: cur_flags[8] = 1;
            29: cur_flags[8] = 0;
            default:
            begin
                if (code >= 30 && code <= 37)
                    cur_fg = 3'(code - 30);
                else if (code >= 40 && code <= 47)
                    cur_bg = 3'(code - 40);
            end
        endcase
    endfunction

    function automatic void move_to(ref out_req_t o, input int r, int c, bit ar, bit ac,
                                    int cr, int cc);
        o.command = CMD_MOVE;
        o.target_row = clip(r, ar, cr, rows_q);
        o.target_col = clip(c, ac, cc, cols_q);
    endfunction

    function automatic void erase(ref out_req_t o, input int r, int c, int n);
        if (n < 0)
            n = 0;
        if (n > 65535)
            n = 65535;
        o.command = CMD_CLEAR;
        o.target_row = 8'(r);
        o.target_col = 8'(c);
        o.clear_count = 16'(n);
    endfunction

    function automatic void run_final(ref out_req_t o, input logic [7:0] fin, int cr, int cc);
        bit one;
        int a1, a0, rw, cl, h0, h1;
        one = nargs <= 1;
        a1 = nargs != 0 ? int'(args[0]) : 1;
        a0 = nargs != 0 ? int'(args[0]) : 0;
        rw = rows_q;
        cl = cols_q;
        if (kind == KIND_PRIV)
        begin
            if ((fin == "h" || fin == "l") && nargs == 1 && args[0] == 16'd25)
            begin
                o.command = CMD_CURSOR;
                o.cursor_visible = fin == "h";
            end
            return;
        end
        if (kind != KIND_CSI)
            return;
        case (fin)
            "A": if (one) move_to(o, -a1, 0, 0, 0, cr, cc);
            "B": if (one) move_to(o, a1, 0, 0, 0, cr, cc);
            "C": if (one) move_to(o, 0, a1, 0, 0, cr, cc);
            "D": if (one) move_to(o, 0, -a1, 0, 0, cr, cc);
            "E": if (one) move_to(o, a1, 0, 0, 1, cr, cc);
            "F": if (one) move_to(o, -a1, 0, 0, 1, cr, cc);
            "G": if (one) move_to(o, 0, a1 - 1, 0, 1, cr, cc);
            "H", "f":
            begin
                if (nargs <= 2)
                begin
                    h0 = nargs >= 1 ? int'(args[0]) : 1;
                    h1 = nargs >= 2 ? int'(args[1]) : 1;
                    move_to(o, h0 - 1, h1 - 1, 1, 1, cr, cc);
                end
            end
            "d": if (one) move_to(o, a1 - 1, 0, 1, 0, cr, cc);
            "J":
            begin
                if (one)
                begin
                    if (a0 == 0)
                        erase(o, cr, cc, (cl - cc) + cl * (rw - cr - 1));
                    else if (a0 == 1)
                        erase(o, 0, 0, cl * cr + cc);
                    else if (a0 == 2)
                        erase(o, 0, 0, cl * rw);
                end
            end
            "K":
            begin
                if (one)
                begin
                    if (a0 == 0)
                        erase(o, cr, cc, cl - cc);
                    else if (a0 == 1)
                        erase(o, cr, 0, cc);
                    else if (a0 == 2)
                        erase(o, cr, 0, cl);
                end
            end
            "S":
            begin
                if (one)
                begin
                    o.command = CMD_SCROLL;
                    o.scroll_rows = 16'(-a1);
                end
            end
            "T":
            begin
                if (one)
                begin
                    o.command = CMD_SCROLL;
                    o.scroll_rows = 16'(a1);
                end
            end
            "m":
            begin
                if (nargs == 0)
                    sgr(0);
                for (int i = 0; i < nargs; i++)
                    sgr(args[i]);
                o.command = CMD_ATTR;
            end
            "s":
            begin
                if (nargs == 0)
                begin
                    sv_row = 8'(cr);
                    sv_col = 8'(cc);
                end
            end
            "u": if (nargs == 0) move_to(o, sv_row, sv_col, 1, 1, cr, cc);
            default: ;
        endcase
    endfunction

    function automatic void add_arg(logic [15:0] v);
        if (nargs < MAX_ARGS)
        begin
            args[nargs] = v;
            nargs++;
        end
    endfunction

    function automatic out_req_t interpret(in_req_t b);
        out_req_t o;
        logic [7:0] ch;
        bit digit;
        int v;
        o = '0;
        ch = b.in_byte;
        digit = ch >= "0" && ch <= "9";
        case (pstate)
            PS_IDLE:
            begin
                if (ch == CH_ESC)
                    pstate = PS_ESC;
                else
                    o.pass_through = 1;
            end
            PS_ESC:
            begin
                if (ch == CH_LBR || ch == CH_RBR)
                begin
                    kind = ch == CH_LBR ? KIND_CSI : KIND_OSC;
                    nargs = 0;
                    pstate = PS_BRACKET;
                end
                else if (ch == CH_LPAR || ch == CH_RPAR)
                    pstate = PS_IGNORE;
                else if (ch != CH_ESC)
                begin
                    pstate = PS_IDLE;
                    o.pass_through = 1;
                end
            end
            PS_BRACKET:
            begin
                if (digit)
                begin
                    add_arg(16'(ch - "0"));
                    pstate = PS_NUMERIC;
                end
                else if (ch == CH_SEMI)
                    add_arg(0);
                else if (ch == CH_QM)
                    kind = KIND_PRIV;
                else
                begin
                    run_final(o, ch, b.cursor_row, b.cursor_col);
                    pstate = PS_IDLE;
                end
            end
            PS_NUMERIC:
            begin
                if (digit)
                begin
                    if (nargs > 0)
                    begin
                        v = int'(args[nargs - 1]) * 10 + int'(ch - "0");
                        if (v > 32767)
                            v = 32767;
                        args[nargs - 1] = 16'(v);
                    end
                end
                else if (ch == CH_SEMI)
                begin
                    add_arg(0);
                    if (kind == KIND_OSC)
                    begin
                        pstate = PS_STRING;
                        str_esc = 0;
                    end
                end
                else
                begin
                    run_final(o, ch, b.cursor_row, b.cursor_col);
                    pstate = PS_IDLE;
                end
            end
            PS_STRING:
            begin
                if (ch == CH_BS || (ch == CH_BSL && str_esc))
                begin
                    pstate = PS_IDLE;
                    str_esc = 0;
                end
                else
                    str_esc = ch == CH_ESC;
            end
            default: pstate = PS_IDLE;
        endcase
        o.attr_fg = cur_fg;
        o.attr_bg = cur_bg;
        o.attr_flags = cur_flags;
        return o;
    endfunction

    initial
        errors = 0;

    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROWS: rows_q = cfg_data[7:0];
                    REG_COLS: cols_q = cfg_data[7:0];
                    REG_FG: dfg = cfg_data[2:0];
                    REG_BG: dbg = cfg_data[2:0];
                    REG_FLAGS: dflags = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_req);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want !== out_req)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, out_req);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                results_due.push_back(interpret(in_req));
        end
    end
endmodule

/* test/ansi_escape_sequence_interpreter_tb.sv */
// ansi_escape_sequence_interpreter_tb: byte stream stimulus, register settings and verdict.
// Depends on aesi_pkg, aesi_checker and the interpreter RTL.
module ansi_escape_sequence_interpreter_tb;
    import aesi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    in_req_t in_req = '0;
    logic out_valid;
    logic out_stall = 0;
    out_req_t out_req;
    logic cfg_we = 0;
    logic [2:0] cfg_index = REG_ROWS;
    logic [8:0] cfg_data = '0;
    int errors;
    int pending;
    int hold_off = 0;
    byte unsigned seq[$];

    ansi_escape_sequence_interpreter uut (.*);

    aesi_checker chk (.*);

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall pattern; hold_off forces a long stretch
    initial
    begin
        int mode;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall <= 1;
                hold_off--;
            end
            else
            begin
                mode = ($time / 20000) % 3;
                out_stall <= mode == 0 ? 0 : ($urandom_range(0, 99) < 30 * mode);
            end
        end
    end

    task automatic send_req(byte unsigned b);
        logic [7:0] row;
        row = 8'($urandom_range(0, 254));
        if ($urandom_range(0, 3) == 0)
            row = 8'($urandom_range(0, 30));
        in_req <= '{in_byte: b, cursor_row: row,
                    cursor_col: 8'($urandom_range(0, 254))};
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
    endtask

    task automatic send_seq();
        while (seq.size() > 0)
            send_req(seq.pop_front());
        in_valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (pending > 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    task automatic push_num(int v);
        string s;
        s = $sformatf("%0d", v);
        foreach (s[i])
            seq.push_back(s[i]);
    endtask

    task automatic build_random();
        byte unsigned finals[] = '{"A", "B", "C", "D", "E", "F", "G", "H", "f", "d",
                                   "J", "K", "S", "T", "m", "s", "u", "h", "l", "x"};
        int n, r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            seq.push_back(8'($urandom_range(0, 255)));
            return;
        end
        seq.push_back(CH_ESC);
        if (r < 17)
        begin
            seq.push_back($urandom_range(0, 1) ? CH_LPAR : 8'($urandom_range(0, 255)));
            seq.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (r < 25)
        begin
            seq.push_back(CH_RBR);
            push_num($urandom_range(0, 2));
            seq.push_back(CH_SEMI);
            repeat ($urandom_range(0, 5))
                seq.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 1))
                seq.push_back(CH_BS);
            else
            begin
                seq.push_back(CH_ESC);
                seq.push_back(CH_BSL);
            end
            return;
        end
        seq.push_back(CH_LBR);
        if (r < 32)
            seq.push_back(CH_QM);
        n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                seq.push_back(CH_SEMI);
            case ($urandom_range(0, 4))
                0: ;
                1: push_num($urandom_range(0, 50));
                2: push_num($urandom_range(0, 300));
                3: push_num($urandom_range(0, 99999));
                default: push_num($urandom_range(0, 1) ? 25 : $urandom_range(0, 9));
            endcase
        end
        seq.push_back(finals[$urandom_range(0, finals.size() - 1)]);
    endtask

    task automatic set_display(int rr, int cc, int fg, int bg, int fl);
        write_reg(REG_ROWS, 9'(rr));
        write_reg(REG_COLS, 9'(cc));
        write_reg(REG_FG, 9'(fg));
        write_reg(REG_BG, 9'(bg));
        write_reg(REG_FLAGS, 9'(fl));
    endtask

    initial
    begin
        string d;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        d = {"a", 8'h00, 8'hff, 8'h1b, "[5A", 8'h1b, "[B", 8'h1b, "[;C", 8'h1b, "[99999D"};
        foreach (d[i])
            seq.push_back(d[i]);
        d = {8'h1b, "[1;2;3;4;5;6;7;8;9;10H", 8'h1b, "[2J", 8'h1b, "[1K", 8'h1b, "[?25l",
             8'h1b, "[?25h", 8'h1b, "[1;4;31;42m", 8'h1b, "[m", 8'h1b, "]0;ti", 8'h1b, "\\",
             8'h1b, "(B", 8'h1b, 8'h1b, "x", 8'h1b, "[3S", 8'h1b, "[T", 8'h1b, "[s",
             8'h1b, "[u", 8'h1b, "[0G", 8'h1b, "[d", 8'h1b, "[Ez"};
        foreach (d[i])
            seq.push_back(d[i]);
        send_seq();
        drain();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_display(255, 255, 0, 7, 511);
                1: set_display(1, 1, 3, 5, 0);
                2: set_display(0, 0, 7, 0, 170);
                default: set_display($urandom_range(1, 255), $urandom_range(1, 255),
                                     $urandom_range(0, 7), $urandom_range(0, 7),
                                     $urandom_range(0, 511));
            endcase
            for (int k = 0; k < 30; k++)
            begin
                if (phase == 1 && k == 10)
                    hold_off = 300;
                build_random();
                send_seq();
                if (k % 7 == 0)
                    repeat ($urandom_range(1, 30))
                        @(negedge clk);
            end
            drain();
        end
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
